// ===== rtl/priority_ready_list_scheduler_top_assert.svh =====
// assertion macros for the priority ready list scheduler
`ifndef PRIORITY_READY_LIST_SCHEDULER_TOP_ASSERT_SVH
`define PRIORITY_READY_LIST_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define PRLS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define PRLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/prls_pkg.sv =====
// shared types and constants of the priority ready list scheduler
package prls_pkg;

    localparam int MODE_W          = 3;
    localparam int TID_W           = 5;
    localparam int PRIO_W          = 3;
    localparam int SUSP_W          = 8;
    localparam int S_TDATA_W       = 16;
    localparam int M_TDATA_W       = 16;
    localparam int M_USED_W        = 12;
    localparam int MAX_THREADS_DEF = 32;
    localparam int NUM_LEVELS_DEF  = 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD     = 3'd0,
        MODE_EXIT    = 3'd1,
        MODE_SUSPEND = 3'd2,
        MODE_RESUME  = 3'd3,
        MODE_YIELD   = 3'd4,
        MODE_START   = 3'd5
    } mode_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [TID_W-1:0]  thread_id;
        logic [PRIO_W-1:0] thread_prio;
    } cmd_t;

    typedef struct packed {
        logic [TID_W-1:0] current_id;
        logic [TID_W-1:0] selected_id;
        logic             switched;
        logic             status;
    } res_t;

endpackage

// ===== rtl/prls_core.sv =====
// scheduler state: per-level linked lists, selection and current thread
module prls_core import prls_pkg::*; #(
    parameter int MAX_THREADS = MAX_THREADS_DEF,
    parameter int NUM_LEVELS  = NUM_LEVELS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic fire,
    input  cmd_t cmd,
    output res_t res
);

    localparam int ID_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int LV_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

    logic [ID_W-1:0]   next_link_reg    [MAX_THREADS];
    logic [ID_W-1:0]   next_link_next   [MAX_THREADS];
    logic [ID_W-1:0]   prev_link_reg    [MAX_THREADS];
    logic [ID_W-1:0]   prev_link_next   [MAX_THREADS];
    logic [LV_W-1:0]   thread_level_reg [MAX_THREADS];
    logic [LV_W-1:0]   thread_level_next[MAX_THREADS];
    logic [MAX_THREADS-1:0] queued_reg, queued_next;
    logic [ID_W-1:0]   level_head_reg   [NUM_LEVELS];
    logic [ID_W-1:0]   level_head_next  [NUM_LEVELS];
    logic [ID_W-1:0]   level_tail_reg   [NUM_LEVELS];
    logic [ID_W-1:0]   level_tail_next  [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] level_nonempty_reg, level_nonempty_next;
    logic              sel_valid_reg, sel_valid_next;
    logic [ID_W-1:0]   selected_reg, selected_next;
    logic [LV_W-1:0]   selected_level_reg, selected_level_next;
    logic              cur_valid_reg, cur_valid_next;
    logic [ID_W-1:0]   current_reg, current_next;
    logic [SUSP_W-1:0] suspend_depth_reg, suspend_depth_next;
    logic              started_reg, started_next;

    logic              tid_ok;
    logic [ID_W-1:0]   tid;
    logic [LV_W-1:0]   add_lv;
    logic [LV_W-1:0]   ul_lv;
    logic              ul_first, ul_last;
    logic [ID_W-1:0]   ul_next, ul_prev;
    logic              pick_found;
    logic [LV_W-1:0]   pick_lv;
    logic              take_req;
    logic              switched, status;

    assign tid_ok = 32'(cmd.thread_id) < MAX_THREADS;
    assign tid    = ID_W'(cmd.thread_id);
    assign add_lv = (32'(cmd.thread_prio) >= NUM_LEVELS) ? LV_W'(NUM_LEVELS - 1)
                                                         : LV_W'(cmd.thread_prio);
    assign ul_lv    = thread_level_reg[tid];
    assign ul_first = level_head_reg[ul_lv] == tid;
    assign ul_last  = level_tail_reg[ul_lv] == tid;
    assign ul_next  = next_link_reg[tid];
    assign ul_prev  = prev_link_reg[tid];

    always_comb begin
        next_link_next      = next_link_reg;
        prev_link_next      = prev_link_reg;
        thread_level_next   = thread_level_reg;
        queued_next         = queued_reg;
        level_head_next     = level_head_reg;
        level_tail_next     = level_tail_reg;
        level_nonempty_next = level_nonempty_reg;
        sel_valid_next      = sel_valid_reg;
        selected_next       = selected_reg;
        selected_level_next = selected_level_reg;
        cur_valid_next      = cur_valid_reg;
        current_next        = current_reg;
        suspend_depth_next  = suspend_depth_reg;
        started_next        = started_reg;
        take_req            = 1'b0;
        switched            = 1'b0;
        status              = 1'b0;
        pick_found          = 1'b0;
        pick_lv             = '0;

        case (cmd.mode)
            MODE_ADD: begin
                if (tid_ok && !queued_reg[tid]) begin
                    // append at the tail of the level list
                    if (level_nonempty_reg[add_lv]) begin
                        next_link_next[level_tail_reg[add_lv]] = tid;
                        prev_link_next[tid] = level_tail_reg[add_lv];
                    end else begin
                        level_head_next[add_lv]     = tid;
                        prev_link_next[tid]         = tid;
                        level_nonempty_next[add_lv] = 1'b1;
                    end
                    next_link_next[tid]    = tid;
                    level_tail_next[add_lv] = tid;
                    thread_level_next[tid] = add_lv;
                    queued_next[tid]       = 1'b1;
                    if (!sel_valid_reg || selected_level_reg < add_lv) begin
                        sel_valid_next      = 1'b1;
                        selected_next       = tid;
                        selected_level_next = add_lv;
                    end else if (selected_reg == tid) begin
                        // re-added selected thread keeps selection, level follows it
                        selected_level_next = add_lv;
                    end
                end
            end
            MODE_EXIT: begin
                if (tid_ok && queued_reg[tid]) begin
                    if (ul_first && ul_last) begin
                        level_nonempty_next[ul_lv] = 1'b0;
                    end else if (ul_first) begin
                        level_head_next[ul_lv] = ul_next;
                    end else if (ul_last) begin
                        level_tail_next[ul_lv] = ul_prev;
                    end else begin
                        next_link_next[ul_prev] = ul_next;
                        prev_link_next[ul_next] = ul_prev;
                    end
                    queued_next[tid] = 1'b0;
                    if (cur_valid_reg && current_reg == tid) begin
                        // highest non-empty level after the unlink
                        for (int l = 0; l < NUM_LEVELS; l++) begin
                            if (level_nonempty_next[l]) begin
                                pick_found = 1'b1;
                                pick_lv    = LV_W'(l);
                            end
                        end
                        if (pick_found) begin
                            sel_valid_next      = 1'b1;
                            selected_next       = level_head_next[pick_lv];
                            selected_level_next = pick_lv;
                        end else begin
                            sel_valid_next = 1'b0;
                            status         = 1'b1;
                        end
                    end
                end
            end
            MODE_SUSPEND: begin
                if (suspend_depth_reg != '1) begin
                    suspend_depth_next = suspend_depth_reg + SUSP_W'(1);
                end
            end
            MODE_RESUME: begin
                if (suspend_depth_reg != '0) begin
                    suspend_depth_next = suspend_depth_reg - SUSP_W'(1);
                    take_req = (suspend_depth_reg == SUSP_W'(1)) && started_reg;
                end
            end
            MODE_YIELD: begin
                take_req = started_reg;
            end
            MODE_START: begin
                take_req = 1'b1;
            end
            default: begin
            end
        endcase

        if (take_req) begin
            if (!sel_valid_reg) begin
                status = 1'b1;
            end else begin
                switched       = !cur_valid_reg || (current_reg != selected_reg);
                cur_valid_next = 1'b1;
                current_next   = selected_reg;
                if (cmd.mode == MODE_START) begin
                    started_next = 1'b1;
                end
            end
        end
    end

    always_comb begin
        res.current_id  = cur_valid_next ? TID_W'(current_next) : '0;
        res.selected_id = sel_valid_next ? TID_W'(selected_next) : '0;
        res.switched    = switched;
        res.status      = status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            queued_reg         <= '0;
            level_nonempty_reg <= '0;
            sel_valid_reg      <= 1'b0;
            cur_valid_reg      <= 1'b0;
            suspend_depth_reg  <= '0;
            started_reg        <= 1'b0;
            for (int l = 0; l < NUM_LEVELS; l++) begin
                level_head_reg[l] <= '0;
                level_tail_reg[l] <= '0;
            end
        end else if (fire) begin
            queued_reg         <= queued_next;
            level_nonempty_reg <= level_nonempty_next;
            sel_valid_reg      <= sel_valid_next;
            cur_valid_reg      <= cur_valid_next;
            suspend_depth_reg  <= suspend_depth_next;
            started_reg        <= started_next;
            level_head_reg     <= level_head_next;
            level_tail_reg     <= level_tail_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            next_link_reg      <= next_link_next;
            prev_link_reg      <= prev_link_next;
            thread_level_reg   <= thread_level_next;
            selected_reg       <= selected_next;
            selected_level_reg <= selected_level_next;
            current_reg        <= current_next;
        end
    end

endmodule

// ===== rtl/priority_ready_list_scheduler_top.sv =====
// top level of the priority ready list scheduler with stream handshakes
// Hardware ready queue for a small real-time kernel: every priority level keeps
// a first-in first-out list of thread ids as doubly linked lists held in
// registers, and each command (add, exit, suspend, resume, yield, start) is
// answered by exactly one result transaction carrying the current thread, the
// selected thread, a switch flag and a status bit (1 means no ready thread).
// The block sustains one command per clock while m_tready stays high: a command
// sits in an input register, goes through one pass of link update and a priority
// encoder over the non-empty levels, and lands in the result register. While a
// result waits for the master side the input side takes one more command into
// the input register, and stalls only when both registers are full. Thread ids
// at or above MAX_THREADS make add and exit do nothing; priorities at or above
// NUM_LEVELS count as the top level. Ids read 0 when no thread is current or
// selected.
module priority_ready_list_scheduler_top import prls_pkg::*; #(
    parameter int MAX_THREADS = MAX_THREADS_DEF,
    parameter int NUM_LEVELS  = NUM_LEVELS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // command channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // mode[2:0], thread_id[7:3], thread_prio[10:8]
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // current_id[4:0], selected_id[9:5],
                                            // switched[10], status[11]
);

    // input register
    logic in_valid_reg, in_valid_next;
    cmd_t in_cmd_reg;

    // result register
    logic out_valid_reg, out_valid_next;
    res_t out_res_reg;
    res_t core_res;

    // a command executes when the result register is free or draining
    logic fire;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (fire) begin
            in_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (fire) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg.mode        <= s_tdata[2:0];
            in_cmd_reg.thread_id   <= s_tdata[7:3];
            in_cmd_reg.thread_prio <= s_tdata[10:8];
        end
        if (fire) begin
            out_res_reg <= core_res;
        end
    end

    // list state, selection and current thread
    prls_core #(
        .MAX_THREADS (MAX_THREADS),
        .NUM_LEVELS  (NUM_LEVELS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .cmd     (in_cmd_reg),
        .res     (core_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - M_USED_W){1'b0}},
                       out_res_reg.status,
                       out_res_reg.switched,
                       out_res_reg.selected_id,
                       out_res_reg.current_id};

endmodule

// ===== rtl/prls_checker.sv =====
// port-level checks of the priority ready list scheduler and their binding
`include "priority_ready_list_scheduler_top_assert.svh"

module prls_checker import prls_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // a switch only happens on success
    `PRLS_ASSERT_NOW(a_switch_ok, aclk, aresetn, m_tvalid && m_tdata[10], !m_tdata[11], "switch reported with error status")
    // after a switch current and selected agree
    `PRLS_ASSERT_NOW(a_switch_same, aclk, aresetn, m_tvalid && m_tdata[10], m_tdata[4:0] == m_tdata[9:5], "switch left current and selected apart")
    // padding above the result fields stays zero
    `PRLS_ASSERT_NOW(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[M_TDATA_W-1:M_USED_W] == '0, "nonzero padding in result")
    // a stalled result holds
    `PRLS_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind priority_ready_list_scheduler_top prls_checker u_prls_checker (.*);

// ===== tb/sv/ready_queue_checker.sv =====
// checker for the priority ready list scheduler: predicts every result and compares it
module ready_queue_checker import prls_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   fail_count,
    output int                   pending,
    output int                   results_seen,
    output int                   switch_seen,
    output int                   empty_seen
);

    localparam int REPORT_LIMIT = 40;

    // predicted scheduler state
    logic [TID_W-1:0]    next_of  [MAX_THREADS_DEF];
    logic [TID_W-1:0]    prev_of  [MAX_THREADS_DEF];
    logic [PRIO_W-1:0]   level_of [MAX_THREADS_DEF];
    bit                  in_list  [MAX_THREADS_DEF];
    logic [TID_W-1:0]    head_of  [NUM_LEVELS_DEF];
    logic [TID_W-1:0]    tail_of  [NUM_LEVELS_DEF];
    bit [NUM_LEVELS_DEF-1:0] level_busy;
    bit                  sel_ok;
    bit                  cur_ok;
    bit                  started;
    logic [TID_W-1:0]    sel_id;
    logic [TID_W-1:0]    cur_id;
    logic [SUSP_W-1:0]   depth;

    res_t expected_q[$];
    int   errors;
    int   n_results;
    int   n_switch;
    int   n_empty;

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= REPORT_LIMIT) begin
            $display("mismatch at result %0d: %s got %0d, expected %0d",
                     n_results, what, got, want);
        end
    endtask

    // selected thread becomes current
    function automatic void grab_selected(output logic sw, output logic st);
        sw = 1'b0;
        st = 1'b0;
        if (!sel_ok) begin
            st = 1'b1;
        end else begin
            if (!cur_ok || cur_id != sel_id) sw = 1'b1;
            cur_id = sel_id;
            cur_ok = 1'b1;
        end
    endfunction

    function automatic res_t schedule_cmd(input logic [MODE_W-1:0] mode,
                                          input logic [TID_W-1:0]  tid,
                                          input logic [PRIO_W-1:0] prio);
        res_t              r;
        logic [PRIO_W-1:0] lv;
        logic              sw;
        logic              st;
        int                k;
        sw = 1'b0;
        st = 1'b0;
        case (mode)
            MODE_ADD: begin
                if (tid < MAX_THREADS_DEF && !in_list[tid]) begin
                    lv = (prio >= NUM_LEVELS_DEF) ? PRIO_W'(NUM_LEVELS_DEF - 1) : prio;
                    if (level_busy[lv]) begin
                        next_of[tail_of[lv]] = tid;
                        prev_of[tid] = tail_of[lv];
                    end else begin
                        head_of[lv] = tid;
                        prev_of[tid] = tid;
                        level_busy[lv] = 1'b1;
                    end
                    next_of[tid] = tid;
                    tail_of[lv] = tid;
                    level_of[tid] = lv;
                    in_list[tid] = 1'b1;
                    if (!sel_ok || level_of[sel_id] < lv) begin
                        sel_id = tid;
                        sel_ok = 1'b1;
                    end
                end
            end
            MODE_EXIT: begin
                if (tid < MAX_THREADS_DEF && in_list[tid]) begin
                    lv = level_of[tid];
                    // neighbor links of a new head or tail are left stale on purpose
                    if (head_of[lv] == tid && tail_of[lv] == tid) begin
                        level_busy[lv] = 1'b0;
                    end else if (head_of[lv] == tid) begin
                        head_of[lv] = next_of[tid];
                    end else if (tail_of[lv] == tid) begin
                        tail_of[lv] = prev_of[tid];
                    end else begin
                        next_of[prev_of[tid]] = next_of[tid];
                        prev_of[next_of[tid]] = prev_of[tid];
                    end
                    in_list[tid] = 1'b0;
                    if (cur_ok && cur_id == tid) begin
                        sel_ok = 1'b0;
                        st = 1'b1;
                        for (k = NUM_LEVELS_DEF - 1; k >= 0 && !sel_ok; k--) begin
                            if (level_busy[k]) begin
                                sel_id = head_of[k];
                                sel_ok = 1'b1;
                                st = 1'b0;
                            end
                        end
                    end
                end
            end
            MODE_SUSPEND: begin
                if (depth != '1) depth = depth + SUSP_W'(1);
            end
            MODE_RESUME: begin
                if (depth != '0) begin
                    depth = depth - SUSP_W'(1);
                    if (depth == '0 && started) grab_selected(sw, st);
                end
            end
            MODE_YIELD: begin
                if (started) grab_selected(sw, st);
            end
            MODE_START: begin
                grab_selected(sw, st);
                if (!st) started = 1'b1;
            end
            default: begin
            end
        endcase
        r.current_id  = cur_ok ? cur_id : '0;
        r.selected_id = sel_ok ? sel_id : '0;
        r.switched    = sw;
        r.status      = st;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        res_t got;
        res_t want;
        int   k;
        if (!aresetn) begin
            for (k = 0; k < MAX_THREADS_DEF; k++) begin
                next_of[k]  = '0;
                prev_of[k]  = '0;
                level_of[k] = '0;
                in_list[k]  = 1'b0;
            end
            for (k = 0; k < NUM_LEVELS_DEF; k++) begin
                head_of[k] = '0;
                tail_of[k] = '0;
            end
            level_busy = '0;
            sel_ok     = 1'b0;
            cur_ok     = 1'b0;
            started    = 1'b0;
            sel_id     = '0;
            cur_id     = '0;
            depth      = '0;
            expected_q.delete();
        end else begin
            // compare first: a result never leaves in the cycle of its own command
            if (m_tvalid && m_tready) begin
                got.current_id  = m_tdata[4:0];
                got.selected_id = m_tdata[9:5];
                got.switched    = m_tdata[10];
                got.status      = m_tdata[11];
                n_results++;
                if (got.switched) n_switch++;
                if (got.status) n_empty++;
                if (expected_q.size() == 0) begin
                    report_mismatch("result transaction with nothing expected",
                                    int'(m_tdata), 0);
                end else begin
                    want = expected_q.pop_front();
                    if (got.current_id != want.current_id)
                        report_mismatch("current_id", int'(got.current_id),
                                        int'(want.current_id));
                    if (got.selected_id != want.selected_id)
                        report_mismatch("selected_id", int'(got.selected_id),
                                        int'(want.selected_id));
                    if (got.switched != want.switched)
                        report_mismatch("switched", int'(got.switched),
                                        int'(want.switched));
                    if (got.status != want.status)
                        report_mismatch("status", int'(got.status), int'(want.status));
                end
            end
            if (s_tvalid && s_tready) begin
                expected_q.push_back(schedule_cmd(s_tdata[2:0], s_tdata[7:3], s_tdata[10:8]));
            end
        end
        fail_count   <= errors;
        pending      <= expected_q.size();
        results_seen <= n_results;
        switch_seen  <= n_switch;
        empty_seen   <= n_empty;
    end

endmodule

// ===== tb/sv/priority_ready_list_scheduler_top_test.sv =====
// top of the scheduler testbench: clock, reset, command stimulus and the verdict
module priority_ready_list_scheduler_top_test;
    import prls_pkg::*;

    // generous bound: every command waiting out the longest sender gap and receiver stall
    localparam int CYCLE_LIMIT = 600000;

    // modes the block must ignore
    localparam logic [MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // mode[2:0], thread_id[7:3], thread_prio[10:8]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // current_id[4:0], selected_id[9:5],
                                           // switched[10], status[11]

    int fail_count;
    int pending;
    int results_seen;
    int switch_seen;
    int empty_seen;

    int cycles = 0;
    int sent   = 0;
    bit no_idle = 1'b0;   // when set, neither side inserts gaps
    int live_ids[$];      // ids added by the stimulus, used to aim exits at queued threads

    priority_ready_list_scheduler_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ready_queue_checker chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .switch_seen  (switch_seen),
        .empty_seen   (empty_seen)
    );

    // 10 time unit clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: bursts of ready with random stalls between them
    initial begin : result_sink
        int run;
        forever begin
            run = $urandom_range(1, 12);
            m_tready <= 1'b1;
            repeat (run) @(posedge aclk);
            run = pick_gap();
            if (run > 0) begin
                m_tready <= 1'b0;
                repeat (run) @(posedge aclk);
            end
        end
    end

    // one command transaction, called at a rising edge; returns at the edge it is taken
    task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [TID_W-1:0] tid,
                            input logic [PRIO_W-1:0] prio);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - MODE_W - TID_W - PRIO_W){1'b0}}, prio, tid, mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    // random commands drawn from a pool of span ids, priorities up to prio_top
    task automatic random_burst(input int count, input int span, input int prio_top);
        int                k;
        int                r;
        int                pick;
        logic [MODE_W-1:0] mode;
        logic [TID_W-1:0]  tid;
        logic [PRIO_W-1:0] prio;
        for (k = 0; k < count; k++) begin
            r    = $urandom_range(0, 99);
            tid  = TID_W'($urandom_range(0, span - 1));
            prio = PRIO_W'($urandom_range(0, prio_top));
            if (r < 32) begin
                mode = MODE_ADD;
                live_ids.push_back(int'(tid));
            end else if (r < 54) begin
                mode = MODE_EXIT;
                // most exits hit a thread that was added, some hit random ids
                if (live_ids.size() > 0 && $urandom_range(0, 3) != 0) begin
                    pick = $urandom_range(0, live_ids.size() - 1);
                    tid  = TID_W'(live_ids[pick]);
                    live_ids.delete(pick);
                end
            end else if (r < 64) begin
                mode = MODE_SUSPEND;
            end else if (r < 76) begin
                mode = MODE_RESUME;
            end else if (r < 90) begin
                mode = MODE_YIELD;
            end else if (r < 97) begin
                mode = MODE_START;
            end else begin
                mode = $urandom_range(0, 1) ? MODE_UNUSED_6 : MODE_UNUSED_7;
            end
            send_cmd(mode, tid, prio);
        end
    endtask

    initial begin : stimulus
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty scheduler corner cases first
        send_cmd(MODE_YIELD,    5'd0,  3'd0);   // yield before start
        send_cmd(MODE_RESUME,   5'd0,  3'd0);   // resume with depth at zero
        send_cmd(MODE_START,    5'd0,  3'd0);   // start with nothing selected
        send_cmd(MODE_UNUSED_6, 5'd31, 3'd7);
        send_cmd(MODE_UNUSED_7, 5'd0,  3'd0);
        // fill three levels, extremes of id and priority
        send_cmd(MODE_ADD,      5'd31, 3'd7);
        send_cmd(MODE_ADD,      5'd0,  3'd0);
        send_cmd(MODE_ADD,      5'd5,  3'd3);
        send_cmd(MODE_ADD,      5'd31, 3'd2);   // already queued, ignored
        send_cmd(MODE_EXIT,     5'd9,  3'd0);   // not queued, ignored
        send_cmd(MODE_YIELD,    5'd0,  3'd0);   // still before start
        send_cmd(MODE_START,    5'd0,  3'd0);
        send_cmd(MODE_ADD,      5'd10, 3'd7);   // same level, selection kept
        send_cmd(MODE_EXIT,     5'd0,  3'd0);   // not current
        send_cmd(MODE_EXIT,     5'd31, 3'd0);   // current leaves, reselect
        send_cmd(MODE_YIELD,    5'd0,  3'd0);
        // nested suspend, resume back to zero
        send_cmd(MODE_SUSPEND,  5'd0,  3'd0);
        send_cmd(MODE_SUSPEND,  5'd0,  3'd0);
        send_cmd(MODE_RESUME,   5'd0,  3'd0);
        send_cmd(MODE_RESUME,   5'd0,  3'd0);
        send_cmd(MODE_EXIT,     5'd10, 3'd0);   // current leaves
        send_cmd(MODE_EXIT,     5'd5,  3'd0);   // selected but not current, kept
        send_cmd(MODE_ADD,      5'd3,  3'd4);
        send_cmd(MODE_YIELD,    5'd0,  3'd0);
        send_cmd(MODE_EXIT,     5'd3,  3'd0);   // current leaves, every level empty
        send_cmd(MODE_START,    5'd0,  3'd0);   // nothing selected

        // suspend depth saturation and the long way back down
        send_cmd(MODE_ADD, 5'd17, 3'd6);
        repeat (257) send_cmd(MODE_SUSPEND, TID_W'($urandom_range(0, 31)),
                              PRIO_W'($urandom_range(0, 7)));
        send_cmd(MODE_YIELD, 5'd0, 3'd0);
        send_cmd(MODE_ADD, 5'd22, 3'd7);
        repeat (256) send_cmd(MODE_RESUME, TID_W'($urandom_range(0, 31)),
                              PRIO_W'($urandom_range(0, 7)));
        send_cmd(MODE_RESUME, 5'd0, 3'd0);      // one below zero attempt

        // random phases: crowded small pools, wide pools, flat priorities
        random_burst(220, 8, 7);
        no_idle = 1'b1;
        random_burst(220, 32, 7);
        no_idle = 1'b0;
        random_burst(220, 4, 1);
        no_idle = 1'b1;
        random_burst(220, 32, 3);
        no_idle = 1'b0;
        random_burst(220, 16, 7);

        // drain: let the last command's expectation register, then wait it out
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("sent %0d scheduler commands, checked %0d result transactions",
                 sent, results_seen);
        $display("results showed %0d thread switches and %0d no-ready-thread reports",
                 switch_seen, empty_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
